// File: rtl/bccm_pkg.sv
package bccm_pkg;

	typedef enum logic [1:0] {
		OP_BOX_BOX   = 2'd0,
		OP_CIRC_CIRC = 2'd1,
		OP_BOX_CIRC  = 2'd2,
		OP_CIRC_BOX  = 2'd3
	} op_t;

	// Q1.14 unit normal
	localparam int NORM_SHIFT = 14;
	localparam logic signed [15:0] UNIT_NORMAL = 16'sd16384;
	// quotient bits of component * 2^14 / distance, at most 2^14
	localparam int Q_BITS = 15;

endpackage

// File: rtl/box_circle_collision_manifold.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | operation, a_*, b_* shape fields
// out     | out_valid / out_ready| hit, normal_x, normal_y, depth
//
// One request enters per cycle while the output is not stalled. The pipeline holds
// the bit-per-stage square root (COORD_BITS stages) and the 15-stage
// normal divider, plus setup, rounding and output stages.
// arst_n clears only the stage valid bits.
// A stalled output freezes the whole pipeline; in_ready follows that stall.
module box_circle_collision_manifold
	import bccm_pkg::*;
#(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic signed [COORD_BITS-1:0] a_pos_x,
	input  logic signed [COORD_BITS-1:0] a_pos_y,
	input  logic [COORD_BITS-2:0]        a_half_x,
	input  logic [COORD_BITS-2:0]        a_half_y,
	input  logic [COORD_BITS-2:0]        a_radius,
	input  logic signed [COORD_BITS-1:0] b_pos_x,
	input  logic signed [COORD_BITS-1:0] b_pos_y,
	input  logic [COORD_BITS-2:0]        b_half_x,
	input  logic [COORD_BITS-2:0]        b_half_y,
	input  logic [COORD_BITS-2:0]        b_radius,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic signed [15:0]           normal_x,
	output logic signed [15:0]           normal_y,
	output logic signed [COORD_BITS-1:0] depth
);

	localparam int C  = COORD_BITS;
	localparam int NW = C + 16;

	typedef struct packed {
		logic                  use_e;
		logic                  hit;
		logic                  neg;
		logic                  zero;
		logic                  gsx;
		logic                  gsy;
		logic signed [15:0]    nx_e;
		logic signed [15:0]    ny_e;
		logic signed [C+1:0]   dep_e;
		logic [C:0]            gxa;
		logic [C:0]            gya;
		logic [C-1:0]          rad;
		logic [C-2:0]          ra;
	} ctx_t;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: centres and differences
	logic                v_s1;
	op_t                 op_s1;
	logic signed [C+1:0] dx_s1, dy_s1;
	logic [C-1:0]        ex_s1, ey_s1, rad_s1;
	logic [C-2:0]        ra_s1;

	logic signed [C+1:0] axw, ayw, bxw, byw, ahxw, ahyw, bhxw, bhyw;
	logic signed [C+1:0] acx, acy, bcx, bcy;
	logic signed [C+1:0] dx1, dy1;
	logic [C-1:0]        ex1, ey1, rad1;
	op_t                 op_in;

	assign axw  = {{2{a_pos_x[C-1]}}, a_pos_x};
	assign ayw  = {{2{a_pos_y[C-1]}}, a_pos_y};
	assign bxw  = {{2{b_pos_x[C-1]}}, b_pos_x};
	assign byw  = {{2{b_pos_y[C-1]}}, b_pos_y};
	assign ahxw = $signed({3'b000, a_half_x});
	assign ahyw = $signed({3'b000, a_half_y});
	assign bhxw = $signed({3'b000, b_half_x});
	assign bhyw = $signed({3'b000, b_half_y});
	assign acx  = axw + ahxw;
	assign acy  = ayw + ahyw;
	assign bcx  = bxw + bhxw;
	assign bcy  = byw + bhyw;
	assign op_in = op_t'(operation);

	always_comb begin
		unique case (op_in)
			OP_BOX_BOX: begin
				dx1  = bcx - acx;
				dy1  = bcy - acy;
				ex1  = {1'b0, a_half_x} + {1'b0, b_half_x};
				ey1  = {1'b0, a_half_y} + {1'b0, b_half_y};
				rad1 = '0;
			end
			OP_CIRC_CIRC: begin
				dx1  = bxw - axw;
				dy1  = byw - ayw;
				ex1  = '0;
				ey1  = '0;
				rad1 = {1'b0, a_radius} + {1'b0, b_radius};
			end
			OP_BOX_CIRC: begin
				dx1  = bxw - acx;
				dy1  = byw - acy;
				ex1  = {1'b0, a_half_x};
				ey1  = {1'b0, a_half_y};
				rad1 = {1'b0, b_radius};
			end
			OP_CIRC_BOX: begin
				dx1  = axw - bcx;
				dy1  = ayw - bcy;
				ex1  = {1'b0, b_half_x};
				ey1  = {1'b0, b_half_y};
				rad1 = {1'b0, a_radius};
			end
			default: begin
				dx1  = '0;
				dy1  = '0;
				ex1  = '0;
				ey1  = '0;
				rad1 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op_in;
			dx_s1  <= dx1;
			dy_s1  <= dy1;
			ex_s1  <= ex1;
			ey_s1  <= ey1;
			rad_s1 <= rad1;
			ra_s1  <= a_radius;
		end
	end

	// ---------------- stage 2: magnitudes and clamp residue
	logic                v_s2;
	op_t                 op_s2;
	logic [C:0]          absx_s2, absy_s2;
	logic                sx_s2, sy_s2;
	logic signed [C+1:0] gx_s2, gy_s2;
	logic [C-1:0]        ex_s2, ey_s2, rad_s2;
	logic [C-2:0]        ra_s2;

	logic signed [C+1:0] nx1, ny1, exw, eyw, gx2c, gy2c;

	assign nx1 = -dx_s1;
	assign ny1 = -dy_s1;
	assign exw = $signed({2'b00, ex_s1});
	assign eyw = $signed({2'b00, ey_s1});

	always_comb begin
		if (op_s1 == OP_CIRC_CIRC || op_s1 == OP_BOX_BOX) begin
			gx2c = dx_s1;
			gy2c = dy_s1;
		end else begin
			if (dx_s1 > exw) gx2c = dx_s1 - exw;
			else if (dx_s1 < -exw) gx2c = dx_s1 + exw;
			else gx2c = '0;
			if (dy_s1 > eyw) gy2c = dy_s1 - eyw;
			else if (dy_s1 < -eyw) gy2c = dy_s1 + eyw;
			else gy2c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			sx_s2   <= dx_s1[C+1];
			sy_s2   <= dy_s1[C+1];
			absx_s2 <= dx_s1[C+1] ? nx1[C:0] : dx_s1[C:0];
			absy_s2 <= dy_s1[C+1] ? ny1[C:0] : dy_s1[C:0];
			gx_s2   <= gx2c;
			gy_s2   <= gy2c;
			ex_s2   <= ex_s1;
			ey_s2   <= ey_s1;
			rad_s2  <= rad_s1;
			ra_s2   <= ra_s1;
		end
	end

	// ---------------- stage 3: squares and overlaps
	logic                v_s3;
	op_t                 op_s3;
	logic [2*C+3:0]      gx2_s3, gy2_s3;
	logic [2*C-1:0]      r2_s3;
	logic signed [C+1:0] ox_s3, oy_s3;
	logic                xgt_s3, inside_s3, sx_s3, sy_s3, ypos_s3;
	logic                gsx_s3, gsy_s3;
	logic [C:0]          gxa_s3, gya_s3;
	logic [C-1:0]        rad_s3;
	logic [C-2:0]        ra_s3;

	logic signed [2*C+3:0] gxsq, gysq;
	logic signed [C+1:0]   ngx, ngy;

	assign gxsq = gx_s2 * gx_s2;
	assign gysq = gy_s2 * gy_s2;
	assign ngx  = -gx_s2;
	assign ngy  = -gy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3     <= op_s2;
			gx2_s3    <= gxsq;
			gy2_s3    <= gysq;
			r2_s3     <= rad_s2 * rad_s2;
			ox_s3     <= $signed({2'b00, ex_s2}) - $signed({1'b0, absx_s2});
			oy_s3     <= $signed({2'b00, ey_s2}) - $signed({1'b0, absy_s2});
			xgt_s3    <= absx_s2 > absy_s2;
			inside_s3 <= (gx_s2 == '0) && (gy_s2 == '0);
			sx_s3     <= sx_s2;
			sy_s3     <= sy_s2;
			ypos_s3   <= !sy_s2 && (absy_s2 != '0);
			gsx_s3    <= gx_s2[C+1];
			gsy_s3    <= gy_s2[C+1];
			gxa_s3    <= gx_s2[C+1] ? ngx[C:0] : gx_s2[C:0];
			gya_s3    <= gy_s2[C+1] ? ngy[C:0] : gy_s2[C:0];
			rad_s3    <= rad_s2;
			ra_s3     <= ra_s2;
		end
	end

	// ---------------- stage 4: hit tests and axis results
	logic           v_s4;
	ctx_t           ctx_s4;
	logic [2*C-1:0] s_s4;

	logic [2*C+3:0] ssum;
	logic           far_hit, use_e, hit_e;
	logic signed [15:0]  nxe, nye;
	logic signed [C+1:0] depe;

	assign ssum    = gx2_s3 + gy2_s3;
	assign far_hit = ssum <= {4'b0000, r2_s3};

	always_comb begin
		nxe   = '0;
		nye   = '0;
		depe  = '0;
		hit_e = 1'b0;
		use_e = 1'b0;
		if (op_s3 == OP_BOX_BOX) begin
			use_e = 1'b1;
			hit_e = (ox_s3 > 0) && (oy_s3 > 0);
			if (ox_s3 < oy_s3) begin
				nxe  = sx_s3 ? -UNIT_NORMAL : UNIT_NORMAL;
				depe = ox_s3;
			end else begin
				nye  = sy_s3 ? -UNIT_NORMAL : UNIT_NORMAL;
				depe = oy_s3;
			end
		end else if (op_s3 != OP_CIRC_CIRC && inside_s3) begin
			// centre inside the box: push out along the axis with the larger centre offset
			use_e = 1'b1;
			hit_e = 1'b1;
			if (xgt_s3) begin
				nxe  = sx_s3 ? -UNIT_NORMAL : UNIT_NORMAL;
				depe = $signed({2'b00, rad_s3}) - ox_s3;
			end else begin
				nye  = ypos_s3 ? UNIT_NORMAL : -UNIT_NORMAL;
				depe = $signed({2'b00, rad_s3}) - oy_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4.use_e <= use_e;
			ctx_s4.hit   <= use_e ? hit_e : far_hit;
			ctx_s4.neg   <= op_s3 == OP_CIRC_BOX;
			ctx_s4.zero  <= ssum == '0;
			ctx_s4.gsx   <= gsx_s3;
			ctx_s4.gsy   <= gsy_s3;
			ctx_s4.nx_e  <= nxe;
			ctx_s4.ny_e  <= nye;
			ctx_s4.dep_e <= depe;
			ctx_s4.gxa   <= gxa_s3;
			ctx_s4.gya   <= gya_s3;
			ctx_s4.rad   <= rad_s3;
			ctx_s4.ra    <= ra_s3;
			// a hit keeps the squared distance below 2^(2C)
			s_s4         <= ssum[2*C-1:0];
		end
	end

	// ---------------- square root, one root bit per stage
	logic           sq_v_s    [C];
	ctx_t           sq_ctx_s  [C];
	logic [2*C-1:0] sq_rem_s  [C];
	logic [C-1:0]   sq_root_s [C];

	for (genvar j = 0; j < C; j++) begin : g_sqrt
		localparam int K = C - 1 - j;
		logic           vin;
		ctx_t           cin;
		logic [2*C-1:0] rin;
		logic [C-1:0]   qin;
		logic [2*C+1:0] trial, rext;
		logic           take;

		if (j == 0) begin : g_first
			assign vin = v_s4;
			assign cin = ctx_s4;
			assign rin = s_s4;
			assign qin = '0;
		end else begin : g_next
			assign vin = sq_v_s[j-1];
			assign cin = sq_ctx_s[j-1];
			assign rin = sq_rem_s[j-1];
			assign qin = sq_root_s[j-1];
		end

		assign trial = ({{(C+2){1'b0}}, qin} << (K + 1)) + ((2*C+2)'(1) << (2 * K));
		assign rext  = {2'b00, rin};
		assign take  = rext >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j] <= 1'b0;
			end else if (en) begin
				sq_v_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctx_s[j]  <= cin;
				sq_rem_s[j]  <= take ? (2*C)'(rext - trial) : rin;
				sq_root_s[j] <= take ? (qin | (C'(1) << K)) : qin;
			end
		end
	end

	// ---------------- round to nearest
	logic       rd_v_s;
	ctx_t       rd_ctx_s;
	logic [C:0] rd_dist_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s <= 1'b0;
		end else if (en) begin
			rd_v_s <= sq_v_s[C-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_ctx_s  <= sq_ctx_s[C-1];
			rd_dist_s <= {1'b0, sq_root_s[C-1]} +
				(C+1)'(sq_rem_s[C-1] > {{C{1'b0}}, sq_root_s[C-1]});
		end
	end

	// ---------------- numerators with half divisor for rounding
	logic          nm_v_s;
	ctx_t          nm_ctx_s;
	logic [C:0]    nm_dist_s;
	logic [NW-1:0] nm_nx_s, nm_ny_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm_v_s <= 1'b0;
		end else if (en) begin
			nm_v_s <= rd_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_ctx_s  <= rd_ctx_s;
			nm_dist_s <= rd_dist_s;
			nm_nx_s   <= (NW'(rd_ctx_s.gxa) << NORM_SHIFT) + NW'(rd_dist_s >> 1);
			nm_ny_s   <= (NW'(rd_ctx_s.gya) << NORM_SHIFT) + NW'(rd_dist_s >> 1);
		end
	end

	// ---------------- restoring divide, one quotient bit per stage
	logic              dv_v_s  [Q_BITS];
	ctx_t              dv_ctx_s[Q_BITS];
	logic [C:0]        dv_d_s  [Q_BITS];
	logic [NW-1:0]     dv_rx_s [Q_BITS];
	logic [NW-1:0]     dv_ry_s [Q_BITS];
	logic [Q_BITS-1:0] dv_qx_s [Q_BITS];
	logic [Q_BITS-1:0] dv_qy_s [Q_BITS];

	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		localparam int I = Q_BITS - 1 - j;
		logic              vin;
		ctx_t              cin;
		logic [C:0]        din;
		logic [NW-1:0]     rxin, ryin, t;
		logic [Q_BITS-1:0] qxin, qyin;

		if (j == 0) begin : g_first
			assign vin  = nm_v_s;
			assign cin  = nm_ctx_s;
			assign din  = nm_dist_s;
			assign rxin = nm_nx_s;
			assign ryin = nm_ny_s;
			assign qxin = '0;
			assign qyin = '0;
		end else begin : g_next
			assign vin  = dv_v_s[j-1];
			assign cin  = dv_ctx_s[j-1];
			assign din  = dv_d_s[j-1];
			assign rxin = dv_rx_s[j-1];
			assign ryin = dv_ry_s[j-1];
			assign qxin = dv_qx_s[j-1];
			assign qyin = dv_qy_s[j-1];
		end

		assign t = NW'(din) << I;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ctx_s[j] <= cin;
				dv_d_s[j]   <= din;
				dv_rx_s[j]  <= (rxin >= t) ? rxin - t : rxin;
				dv_ry_s[j]  <= (ryin >= t) ? ryin - t : ryin;
				dv_qx_s[j]  <= (rxin >= t) ? (qxin | (Q_BITS'(1) << I)) : qxin;
				dv_qy_s[j]  <= (ryin >= t) ? (qyin | (Q_BITS'(1) << I)) : qyin;
			end
		end
	end

	// ---------------- select, negate, saturate, output register
	localparam logic signed [C+1:0] DEP_MAX = (C+2)'((64'sd1 <<< (C - 1)) - 1);
	localparam logic signed [C+1:0] DEP_MIN = -(C+2)'(64'sd1 <<< (C - 1));

	ctx_t                cf;
	logic signed [15:0]  qx, qy, fnx, fny;
	logic signed [C+1:0] fdep;

	assign cf = dv_ctx_s[Q_BITS-1];
	assign qx = $signed({1'b0, dv_qx_s[Q_BITS-1]});
	assign qy = $signed({1'b0, dv_qy_s[Q_BITS-1]});

	always_comb begin
		if (cf.use_e) begin
			fnx  = cf.nx_e;
			fny  = cf.ny_e;
			fdep = cf.dep_e;
		end else if (cf.zero) begin
			// coincident circle centres
			fnx  = UNIT_NORMAL;
			fny  = '0;
			fdep = $signed({3'b000, cf.ra});
		end else begin
			fnx  = cf.gsx ? -qx : qx;
			fny  = cf.gsy ? -qy : qy;
			fdep = $signed({2'b00, cf.rad}) - $signed({1'b0, dv_d_s[Q_BITS-1]});
		end
		if (cf.neg) begin
			fnx = -fnx;
			fny = -fny;
		end
		if (fdep > DEP_MAX) fdep = DEP_MAX;
		else if (fdep < DEP_MIN) fdep = DEP_MIN;
		if (!cf.hit) begin
			fnx  = '0;
			fny  = '0;
			fdep = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v_s[Q_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit      <= cf.hit;
			normal_x <= fnx;
			normal_y <= fny;
			depth    <= fdep[C-1:0];
		end
	end

endmodule

// File: test/box_circle_collision_manifold_tb.sv
module box_circle_collision_manifold_tb;
	import bccm_pkg::*;

	localparam int CW = 24;
	localparam int UNIT = 16384;
	localparam int LATENCY = CW + 22;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1950;

	typedef struct packed {
		op_t                  op;
		logic signed [CW-1:0] ax, ay;
		logic [CW-2:0]        ahx, ahy, ar;
		logic signed [CW-1:0] bx, by;
		logic [CW-2:0]        bhx, bhy, br;
	} pair_t;

	typedef struct packed {
		logic                 hit;
		logic signed [15:0]   nx, ny;
		logic signed [CW-1:0] dep;
	} contact_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	pair_t cur;
	logic hit_o;
	logic signed [15:0] nx_o, ny_o;
	logic signed [CW-1:0] dep_o;

	pair_t pending_pairs[$];
	contact_t expected_contacts[$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0, gap_left = 0;
	bit stim_done = 0;
	bit in_taken = 0;

	box_circle_collision_manifold #(.COORD_BITS(CW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(cur.op),
		.a_pos_x(cur.ax), .a_pos_y(cur.ay),
		.a_half_x(cur.ahx), .a_half_y(cur.ahy), .a_radius(cur.ar),
		.b_pos_x(cur.bx), .b_pos_y(cur.by),
		.b_half_x(cur.bhx), .b_half_y(cur.bhy), .b_radius(cur.br),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit_o), .normal_x(nx_o), .normal_y(ny_o), .depth(dep_o)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint iabs(longint v);
		return v < 0 ? -v : v;
	endfunction

	// nearest integer square root of a value up to 2^100
	function automatic longint nearest_root(logic [127:0] v);
		logic [127:0] r, c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= v)
				r = c;
		end
		if (v > r * r + r)
			r = r + 1;
		return longint'(r);
	endfunction

	function automatic longint unit_comp(longint comp, longint span);
		longint q;
		q = (iabs(comp) * UNIT + span / 2) / span;
		return comp < 0 ? -q : q;
	endfunction

	function automatic logic [127:0] sq_sum(longint x, longint y);
		logic [127:0] ux, uy;
		ux = iabs(x);
		uy = iabs(y);
		return ux * ux + uy * uy;
	endfunction

	function automatic bit box_vs_circle(longint cx, longint cy, longint ex, longint ey,
			longint px, longint py, longint r, output longint nx, output longint ny,
			output longint dep);
		longint dx, dy, qx, qy, gx, gy, span;
		logic [127:0] s, rr;
		dx = px - cx;
		dy = py - cy;
		qx = dx > ex ? ex : (dx < -ex ? -ex : dx);
		qy = dy > ey ? ey : (dy < -ey ? -ey : dy);
		nx = 0;
		ny = 0;
		dep = 0;
		if (qx == dx && qy == dy) begin
			if (iabs(dx) > iabs(dy)) begin
				nx = dx > 0 ? UNIT : -UNIT;
				dep = r - (ex - iabs(dx));
			end else begin
				ny = dy > 0 ? UNIT : -UNIT;
				dep = r - (ey - iabs(dy));
			end
			return 1;
		end
		gx = dx - qx;
		gy = dy - qy;
		s = sq_sum(gx, gy);
		rr = r;
		if (s > rr * rr)
			return 0;
		span = nearest_root(s);
		nx = unit_comp(gx, span);
		ny = unit_comp(gy, span);
		dep = r - span;
		return 1;
	endfunction

	function automatic contact_t predict_contact(pair_t p);
		contact_t c;
		longint ax, ay, ahx, ahy, ar, bx, by, bhx, bhy, br;
		longint nx, ny, dep, dx, dy, ox, oy, sum, span;
		logic [127:0] s, ss;
		bit h;
		ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
		ahx = p.ahx; ahy = p.ahy; ar = p.ar;
		bhx = p.bhx; bhy = p.bhy; br = p.br;
		nx = 0; ny = 0; dep = 0; h = 0;
		case (p.op)
			OP_BOX_BOX: begin
				dx = (bx + bhx) - (ax + ahx);
				dy = (by + bhy) - (ay + ahy);
				ox = ahx + bhx - iabs(dx);
				oy = ahy + bhy - iabs(dy);
				if (ox > 0 && oy > 0) begin
					h = 1;
					if (ox < oy) begin
						nx = dx < 0 ? -UNIT : UNIT;
						dep = ox;
					end else begin
						ny = dy < 0 ? -UNIT : UNIT;
						dep = oy;
					end
				end
			end
			OP_CIRC_CIRC: begin
				dx = bx - ax;
				dy = by - ay;
				sum = ar + br;
				s = sq_sum(dx, dy);
				ss = sum;
				if (s <= ss * ss) begin
					h = 1;
					span = nearest_root(s);
					if (span != 0) begin
						nx = unit_comp(dx, span);
						ny = unit_comp(dy, span);
						dep = sum - span;
					end else begin
						nx = UNIT;
						dep = ar;
					end
				end
			end
			OP_BOX_CIRC:
				h = box_vs_circle(ax + ahx, ay + ahy, ahx, ahy, bx, by, br, nx, ny, dep);
			default: begin
				h = box_vs_circle(bx + bhx, by + bhy, bhx, bhy, ax, ay, ar, nx, ny, dep);
				nx = -nx;
				ny = -ny;
			end
		endcase
		if (!h) begin
			nx = 0; ny = 0; dep = 0;
		end
		if (dep > 64'sd8388607)
			dep = 8388607;
		if (dep < -64'sd8388608)
			dep = -8388608;
		c.hit = h;
		c.nx = nx[15:0];
		c.ny = ny[15:0];
		c.dep = dep[CW-1:0];
		return c;
	endfunction

	function automatic logic [CW-2:0] rand_size();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return (CW-1)'($urandom_range(0, 3));
			2, 3: return (CW-1)'($urandom);
			default: return (CW-1)'($urandom_range(0, 4095));
		endcase
	endfunction

	// mostly near pairs so hits and every branch are common
	function automatic pair_t rand_pair();
		pair_t p;
		int spread;
		p.op = op_t'($urandom_range(0, 3));
		p.ax = CW'($urandom);
		p.ay = CW'($urandom);
		p.ahx = rand_size(); p.ahy = rand_size(); p.ar = rand_size();
		p.bhx = rand_size(); p.bhy = rand_size(); p.br = rand_size();
		if ($urandom_range(0, 9) < 8) begin
			spread = 1 << $urandom_range(1, 14);
			p.bx = CW'(p.ax + $signed($urandom_range(0, 2 * spread)) - spread);
			p.by = CW'(p.ay + $signed($urandom_range(0, 2 * spread)) - spread);
			if ($urandom_range(0, 5) == 0)
				p.by = p.ay;
		end else begin
			p.bx = CW'($urandom);
			p.by = CW'($urandom);
		end
		return p;
	endfunction

	function automatic pair_t mk(op_t op, int ax, int ay, int ahx, int ahy, int ar,
			int bx, int by, int bhx, int bhy, int br);
		pair_t p;
		p.op = op; p.ax = CW'(ax); p.ay = CW'(ay);
		p.ahx = (CW-1)'(ahx); p.ahy = (CW-1)'(ahy); p.ar = (CW-1)'(ar);
		p.bx = CW'(bx); p.by = CW'(by);
		p.bhx = (CW-1)'(bhx); p.bhy = (CW-1)'(bhy); p.br = (CW-1)'(br);
		return p;
	endfunction

	initial begin
		int mx, mn, mh;
		mx = 8388607; mn = -8388608; mh = 8388607;
		// box-box: overlap, touching, equal overlaps, coincident centers
		pending_pairs.push_back(mk(OP_BOX_BOX, 0, 0, 100, 50, 0, 150, 10, 100, 50, 0));
		pending_pairs.push_back(mk(OP_BOX_BOX, 0, 0, 100, 100, 0, 200, 0, 100, 100, 0));
		pending_pairs.push_back(mk(OP_BOX_BOX, 0, 0, 100, 100, 0, 50, 50, 100, 100, 0));
		pending_pairs.push_back(mk(OP_BOX_BOX, 10, 10, 100, 100, 0, 10, 10, 100, 100, 0));
		pending_pairs.push_back(mk(OP_BOX_BOX, mx, mx, mh, mh, mh, mn, mn, mh, mh, mh));
		pending_pairs.push_back(mk(OP_BOX_BOX, mn, mn, mh, mh, 0, mn, mn, mh, mh, 0));
		// circles: same center, touching, apart, diagonal
		pending_pairs.push_back(mk(OP_CIRC_CIRC, 5, 5, 0, 0, 30, 5, 5, 0, 0, 20));
		pending_pairs.push_back(mk(OP_CIRC_CIRC, 0, 0, 0, 0, 3, 3, 4, 0, 0, 2));
		pending_pairs.push_back(mk(OP_CIRC_CIRC, 0, 0, 0, 0, 3, 3, 4, 0, 0, 1));
		pending_pairs.push_back(mk(OP_CIRC_CIRC, 0, 0, 0, 0, 100, -70, 33, 0, 0, 9));
		pending_pairs.push_back(mk(OP_CIRC_CIRC, mn, mn, mh, mh, mh, mx, mx, mh, mh, mh));
		pending_pairs.push_back(mk(OP_CIRC_CIRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// box-circle: inside x face, inside y face, on a face, outside corner
		pending_pairs.push_back(mk(OP_BOX_CIRC, 0, 0, 100, 100, 0, 190, 110, 0, 0, 5));
		pending_pairs.push_back(mk(OP_BOX_CIRC, 0, 0, 100, 100, 0, 90, 20, 0, 0, 5));
		pending_pairs.push_back(mk(OP_BOX_CIRC, 0, 0, 100, 100, 0, 200, 100, 0, 0, 0));
		pending_pairs.push_back(mk(OP_BOX_CIRC, 0, 0, 100, 100, 0, 100, 100, 0, 0, 7));
		pending_pairs.push_back(mk(OP_BOX_CIRC, 0, 0, 100, 100, 0, 210, 210, 0, 0, 20));
		pending_pairs.push_back(mk(OP_BOX_CIRC, 0, 0, 100, 100, 0, 230, 230, 0, 0, 20));
		pending_pairs.push_back(mk(OP_BOX_CIRC, mn, mn, mh, mh, 0, mx, mx, 0, 0, mh));
		// circle-box mirrors
		pending_pairs.push_back(mk(OP_CIRC_BOX, 190, 110, 0, 0, 5, 0, 0, 100, 100, 0));
		pending_pairs.push_back(mk(OP_CIRC_BOX, -15, 50, 0, 0, 20, 0, 0, 100, 100, 0));
		pending_pairs.push_back(mk(OP_CIRC_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(mk(OP_CIRC_BOX, mx, mn, mh, mh, mh, mn, mx, mh, mh, mh));
		for (int i = 0; i < N_RANDOM; i++)
			pending_pairs.push_back(rand_pair());
		stim_done = 1;
	end

	// record each request at the edge that accepts it
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_contacts.push_back(predict_contact(cur));
		in_taken <= arst_n && in_valid && in_ready;
	end

	// driver: bursts with random gaps; hold the request until accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (pending_pairs.size() > 0) begin
				cur <= pending_pairs.pop_front();
				in_valid <= 1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver stall pattern: phases of always ready, random, and long stalls
	always @(negedge clk) begin
		int ph;
		ph = int'(($time / 400) % 4);
		if (!arst_n)
			out_ready <= 0;
		else if (ph == 0)
			out_ready <= 1;
		else if (ph == 3)
			out_ready <= ($urandom_range(0, 7) == 0);
		else
			out_ready <= $urandom_range(0, 1);
	end

	// monitor
	always @(posedge clk) begin
		contact_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_contacts.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				e = expected_contacts.pop_front();
				if (hit_o !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit_o);
					errors++;
				end
				if (nx_o !== e.nx) begin
					$error("normal_x: expected %0d, got %0d", e.nx, nx_o);
					errors++;
				end
				if (ny_o !== e.ny) begin
					$error("normal_y: expected %0d, got %0d", e.ny, ny_o);
					errors++;
				end
				if (dep_o !== e.dep) begin
					$error("depth: expected %0d, got %0d", e.dep, dep_o);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		cur = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (stim_done);
		while (pending_pairs.size() > 0 || in_valid || expected_contacts.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && expected_contacts.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
